FILE: rtl/button_debounce_short_long_press_top_assert.svh
// Assertion helpers for the button debouncer.
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BDSLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BDSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bdslp_pkg.sv
package bdslp_pkg;

  // Register widths
  localparam int unsigned DebTicksW  = 8;
  localparam int unsigned LongTicksW = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounceTicks  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPressTicks = 2'd1;

  // Register reset values
  localparam logic [DebTicksW-1:0]  DebTicksRst  = 8'd20;
  localparam logic [LongTicksW-1:0] LongTicksRst = 16'd1000;

  // Default long countdown width
  localparam int unsigned LongCountWidthDef = 16;

endpackage

FILE: rtl/button_debounce_short_long_press_top.sv
// Button debouncer with short/long press detection. Each accepted request is one
// sample tick of the raw active-low pin; every tick yields exactly one result with
// the debounced state and the press, release, short and long events of that tick.
// The block takes one tick per clock cycle: the whole update of the debounce and
// long-press countdowns is combinational and lands in the output register, so
// a new tick is accepted whenever the output register is empty or being taken.
// A change of the raw level restarts the debounce countdown (debounce_ticks, 0
// acts as 1); at its expiry the pin is sampled. A debounced press starts the
// long countdown (long_press_ticks, saturated to LONG_COUNT_WIDTH bits, 0 acts as
// 1). Write the registers only while no result is outstanding.
module button_debounce_short_long_press_top #(
  parameter int unsigned LONG_COUNT_WIDTH = bdslp_pkg::LongCountWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [bdslp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bdslp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // tick request
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             pin_level_i,
  // result
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             is_down_o,
  output logic                             change_event_o,
  output logic                             press_event_o,
  output logic                             release_event_o,
  output logic                             short_event_o,
  output logic                             long_event_o
);
  import bdslp_pkg::*;

  localparam int unsigned LW = LONG_COUNT_WIDTH;

  // Configuration registers
  logic [DebTicksW-1:0]  deb_ticks_q;
  logic [LongTicksW-1:0] long_ticks_q;

  // Tick state
  logic          prev_raw_q, prev_raw_d;
  logic [DebTicksW-1:0] deb_left_q, deb_left_d;
  logic          deb_run_q, deb_run_d;
  logic          held_q, held_d;
  logic [LW-1:0] long_left_q, long_left_d;
  logic          long_run_q, long_run_d;
  logic          long_done_q, long_done_d;

  // Result register
  logic out_valid_q;
  logic change_q, press_q, release_q, short_q, long_q, is_down_q;
  logic change_d, press_d, release_d, short_d, long_d;

  logic          in_acc;
  logic          deb_exp, long_exp;
  logic [DebTicksW-1:0] deb_load;
  logic [LW-1:0] long_load;
  logic [31:0]   long_ext, long_max;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Countdown load values
  always_comb begin
    deb_load = (deb_ticks_q == '0) ? DebTicksW'(1) : deb_ticks_q;
    long_ext = 32'(long_ticks_q);
    long_max = 32'({LW{1'b1}});
    if (long_ext > long_max) begin
      long_load = {LW{1'b1}};
    end else begin
      long_load = LW'(long_ext);
    end
    if (long_load == '0) begin
      long_load = LW'(1);
    end
  end

  // Single-tick update
  always_comb begin
    prev_raw_d  = prev_raw_q;
    deb_left_d  = deb_left_q;
    deb_run_d   = deb_run_q;
    held_d      = held_q;
    long_left_d = long_left_q;
    long_run_d  = long_run_q;
    long_done_d = long_done_q;
    deb_exp     = 1'b0;
    long_exp    = 1'b0;
    change_d    = 1'b0;
    press_d     = 1'b0;
    release_d   = 1'b0;
    short_d     = 1'b0;
    long_d      = 1'b0;

    // debounce countdown, restarted by any raw edge
    if (pin_level_i != prev_raw_q) begin
      deb_left_d = deb_load;
      deb_run_d  = 1'b1;
      prev_raw_d = pin_level_i;
    end else if (deb_run_q) begin
      deb_left_d = deb_left_q - DebTicksW'(1);
      if (deb_left_d == '0) begin
        deb_run_d = 1'b0;
        deb_exp   = 1'b1;
      end
    end

    // long-press countdown
    if (long_run_q) begin
      long_left_d = long_left_q - LW'(1);
      if (long_left_d == '0) begin
        long_run_d = 1'b0;
        long_exp   = 1'b1;
      end
    end

    // debounced sample wins over long expiry
    if (deb_exp) begin
      if (!pin_level_i && !held_q) begin
        held_d      = 1'b1;
        long_done_d = 1'b0;
        long_left_d = long_load;
        long_run_d  = 1'b1;
        long_exp    = 1'b0;
        press_d     = 1'b1;
        change_d    = 1'b1;
      end else if (pin_level_i && held_q) begin
        held_d      = 1'b0;
        long_run_d  = 1'b0;
        long_left_d = '0;
        long_exp    = 1'b0;
        release_d   = 1'b1;
        short_d     = ~long_done_q;
        change_d    = 1'b1;
      end
    end

    if (long_exp && !pin_level_i) begin
      long_done_d = 1'b1;
      long_d      = 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q  <= DebTicksRst;
      long_ticks_q <= LongTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDebounceTicks:  deb_ticks_q  <= cfg_wdata_i[DebTicksW-1:0];
        CfgLongPressTicks: long_ticks_q <= cfg_wdata_i[LongTicksW-1:0];
        default: ;
      endcase
    end
  end

  // Tick state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q  <= 1'b1;
      deb_left_q  <= '0;
      deb_run_q   <= 1'b0;
      held_q      <= 1'b0;
      long_left_q <= '0;
      long_run_q  <= 1'b0;
      long_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_raw_q  <= prev_raw_d;
        deb_left_q  <= deb_left_d;
        deb_run_q   <= deb_run_d;
        held_q      <= held_d;
        long_left_q <= long_left_d;
        long_run_q  <= long_run_d;
        long_done_q <= long_done_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_down_q <= held_d;
      change_q  <= change_d;
      press_q   <= press_d;
      release_q <= release_d;
      short_q   <= short_d;
      long_q    <= long_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_down_o       = is_down_q;
  assign change_event_o  = change_q;
  assign press_event_o   = press_q;
  assign release_event_o = release_q;
  assign short_event_o   = short_q;
  assign long_event_o    = long_q;

`include "button_debounce_short_long_press_top_assert.svh"

  `BDSLP_ASSERT_IMPL(a_change_is_edge, clk_i, rst_ni, out_valid_q, change_q == (press_q | release_q), "change event without press or release")
  `BDSLP_ASSERT_IMPL(a_short_on_release, clk_i, rst_ni, out_valid_q && short_q, release_q && !long_q && !is_down_q, "short event outside a release")
  `BDSLP_ASSERT_IMPL(a_long_needs_held, clk_i, rst_ni, long_run_q, held_q, "long countdown running while released")
  `BDSLP_ASSERT_NEXT(a_press_sets_down, clk_i, rst_ni, in_acc && press_d, is_down_q && out_valid_q, "press did not set debounced state")

endmodule
